// ===== sv/cfa_pkg.sv =====
// cfa_pkg: shared types and codes of the contiguous frame allocator
// used by cfa_engine and contiguous_frame_allocator_top
package cfa_pkg;

	localparam int FRAME_W   = 20;
	localparam int CFG_CNT_W = 11;
	localparam int OC_W      = 3;

	// actions
	localparam logic [1:0] ACT_INIT    = 2'd0;
	localparam logic [1:0] ACT_ALLOC   = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;
	localparam logic [1:0] ACT_MARK    = 2'd3;

	// outcomes
	localparam logic [OC_W-1:0] OC_OK       = 3'd0;
	localparam logic [OC_W-1:0] OC_NOSPACE  = 3'd1;
	localparam logic [OC_W-1:0] OC_RANGE    = 3'd2;
	localparam logic [OC_W-1:0] OC_NOTHEAD  = 3'd3;
	localparam logic [OC_W-1:0] OC_BADCOUNT = 3'd4;

	// frame states
	localparam logic [1:0] FS_FREE = 2'd0;
	localparam logic [1:0] FS_USED = 2'd1;
	localparam logic [1:0] FS_HEAD = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_BASE  = 2'd0;
	localparam logic [1:0] CFG_POOL  = 2'd1;
	localparam logic [1:0] CFG_RESV  = 2'd2;

	typedef struct packed {
		logic [FRAME_W-1:0]   base_frame;
		logic [CFG_CNT_W-1:0] pool_frames;
		logic [CFG_CNT_W-1:0] reserved_frames;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           action;
		logic [FRAME_W-1:0]   frame_number;
		logic [CFG_CNT_W-1:0] frame_count;
	} req_t;

	typedef struct packed {
		logic               ready;
		logic               done;
		logic [FRAME_W-1:0] first_frame;
		logic [OC_W-1:0]    outcome;
	} rsp_t;

endpackage

// ===== sv/cfa_engine.sv =====
// cfa_engine: frame state memory and the sequencer that scans and updates it
// depends on cfa_pkg
module cfa_engine
	import cfa_pkg::*;
#(
	parameter int MAX_FRAMES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	input  cfg_t cfg,
	input  logic take,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int CW    = IDX_W + 1;
	localparam int NW    = (CW > CFG_CNT_W) ? CW : CFG_CNT_W;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_FRAMES);
	localparam logic [CW-1:0] LAST  = CW'(MAX_FRAMES - 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_INIT, S_ASCAN, S_AWR, S_RHEAD, S_RSCAN, S_MARK, S_DONE
	} st_t;

	st_t state_q;

	logic [1:0] mem [MAX_FRAMES];
	logic [1:0] rdata_q;

	logic [CW-1:0] ptr_q, end_q, start_q, iss_q, run_q, cnt_q, n_q, r_q, idx_q;
	logic [CW-1:0] chk_s1;
	logic          vld_s1;
	logic [FRAME_W-1:0] first_q;
	logic [OC_W-1:0]    oc_q;

	logic [NW-1:0] pool_n, n_w, resv_n, r_w, cnt_n, room;
	logic [FRAME_W-1:0] idx_w;
	logic in_pool, iss_ok, last_wr;
	logic [CW-1:0] run_nxt, found_start;

	logic          we;
	logic [CW-1:0] wa;
	logic [1:0]    wd;
	logic [IDX_W-1:0] rd_addr;

	always_comb begin
		pool_n  = NW'(cfg.pool_frames);
		n_w     = (pool_n < MAX_N) ? pool_n : MAX_N;
		resv_n  = NW'(cfg.reserved_frames);
		r_w     = (resv_n < n_w) ? resv_n : n_w;
		cnt_n   = NW'(req.frame_count);
		idx_w   = req.frame_number - cfg.base_frame;
		in_pool = idx_w < FRAME_W'(n_w);
		room    = n_w - NW'(idx_w);
		iss_ok  = iss_q < n_q;
		run_nxt = run_q + CW'(1);
		found_start = chk_s1 - cnt_q + CW'(1);
		last_wr = (ptr_q + CW'(1)) == end_q;
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = FS_USED;
		rd_addr = iss_q[IDX_W-1:0];
		unique case (state_q)
			S_CLR, S_INIT: begin
				we = 1'b1;
				wd = (ptr_q < r_q) ? FS_USED : FS_FREE;
			end
			S_AWR: begin
				we = 1'b1;
				wd = (ptr_q == start_q) ? FS_HEAD : FS_USED;
			end
			S_MARK: begin
				we = 1'b1;
			end
			S_RHEAD: begin
				we = (rdata_q == FS_HEAD);
				wa = idx_q;
				wd = FS_FREE;
			end
			S_RSCAN: begin
				we = vld_s1 && (rdata_q == FS_USED);
				wa = chk_s1;
				wd = FS_FREE;
			end
			S_IDLE: begin
				rd_addr = idx_w[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa[IDX_W-1:0]] <= wd;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ptr_q   <= '0;
			r_q     <= '0;
			vld_s1  <= 1'b0;
			end_q   <= '0;
			n_q     <= '0;
			start_q <= '0;
			iss_q   <= '0;
			run_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			chk_s1  <= '0;
			first_q <= '0;
			oc_q    <= OC_OK;
		end else begin
			unique case (state_q)
				S_CLR: begin
					ptr_q <= ptr_q + CW'(1);
					if (ptr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						n_q     <= CW'(n_w);
						first_q <= '0;
						oc_q    <= OC_OK;
						idx_q   <= CW'(idx_w);
						cnt_q   <= CW'(req.frame_count);
						unique case (req.action)
							ACT_INIT: begin
								r_q     <= CW'(r_w);
								ptr_q   <= '0;
								state_q <= S_INIT;
							end
							ACT_ALLOC: begin
								iss_q <= '0;
								run_q <= '0;
								if (cnt_n == '0 || (n_w != '0 && cnt_n > n_w)) begin
									oc_q    <= OC_BADCOUNT;
									state_q <= S_DONE;
								end else if (n_w == '0) begin
									oc_q    <= OC_NOSPACE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_ASCAN;
								end
							end
							ACT_RELEASE: begin
								iss_q <= CW'(idx_w) + CW'(1);
								if (!in_pool) begin
									oc_q    <= OC_RANGE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RHEAD;
								end
							end
							ACT_MARK: begin
								ptr_q <= CW'(idx_w);
								end_q <= CW'(idx_w) + CW'(req.frame_count);
								if (cnt_n == '0) begin
									oc_q    <= OC_BADCOUNT;
									state_q <= S_DONE;
								end else if (!in_pool || cnt_n > room) begin
									oc_q    <= OC_RANGE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_MARK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INIT: begin
					ptr_q <= ptr_q + CW'(1);
					if (ptr_q == LAST) begin
						state_q <= S_DONE;
					end
				end
				S_ASCAN: begin
					vld_s1 <= iss_ok;
					chk_s1 <= iss_q;
					if (iss_ok) begin
						iss_q <= iss_q + CW'(1);
					end
					if (vld_s1) begin
						if (rdata_q == FS_FREE) begin
							run_q <= run_nxt;
							if (run_nxt == cnt_q) begin
								start_q <= found_start;
								ptr_q   <= found_start;
								end_q   <= chk_s1 + CW'(1);
								state_q <= S_AWR;
							end
						end else begin
							run_q <= '0;
						end
					end else if (!iss_ok) begin
						oc_q    <= OC_NOSPACE;
						state_q <= S_DONE;
					end
				end
				S_AWR: begin
					ptr_q <= ptr_q + CW'(1);
					if (last_wr) begin
						first_q <= cfg.base_frame + FRAME_W'(start_q);
						state_q <= S_DONE;
					end
				end
				S_MARK: begin
					ptr_q <= ptr_q + CW'(1);
					if (last_wr) begin
						state_q <= S_DONE;
					end
				end
				S_RHEAD: begin
					if (rdata_q != FS_HEAD) begin
						oc_q    <= OC_NOTHEAD;
						state_q <= S_DONE;
					end else begin
						vld_s1 <= iss_ok;
						chk_s1 <= iss_q;
						if (iss_ok) begin
							iss_q <= iss_q + CW'(1);
						end
						state_q <= S_RSCAN;
					end
				end
				S_RSCAN: begin
					if (vld_s1 && rdata_q == FS_USED) begin
						vld_s1 <= iss_ok;
						chk_s1 <= iss_q;
						if (iss_ok) begin
							iss_q <= iss_q + CW'(1);
						end
					end else begin
						vld_s1  <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.ready       = (state_q == S_IDLE);
	assign rsp.done        = (state_q == S_DONE);
	assign rsp.first_frame = first_q;
	assign rsp.outcome     = oc_q;

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.done && oc_q != OC_OK) |-> first_q == '0)
		else $error("first frame nonzero on failed action");

	a_wr_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != S_CLR && state_q != S_INIT) |-> wa < n_q)
		else $error("frame state write outside pool");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AWR || state_q == S_MARK) |-> (end_q <= n_q && ptr_q < end_q))
		else $error("write run leaves pool");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN) |-> run_q < cnt_q)
		else $error("free run counter overran count");

endmodule

// ===== sv/contiguous_frame_allocator_top.sv =====
// contiguous_frame_allocator_top: configuration registers, stream ports and result register
// depends on cfa_pkg and cfa_engine
// init rewrites every frame; allocate scans the pool and then writes the run back, one frame per cycle
// through the state memory, which has one write port and one read port; release frees the run;
// mark inaccessible writes count frames; rejected items go straight to the result. one item at a time.
// reset: registers return to base 0, pool 1024, reserved 0; a clearing sweep over all MAX_FRAMES
// frames frees every frame while s_tready stays low.
module contiguous_frame_allocator_top
	import cfa_pkg::*;
#(
	parameter int MAX_FRAMES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // frame_number[19:0], frame_count[30:20], zero pad
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // first_frame[19:0], outcome[22:20], zero pad
);

	cfg_t cfg_q;
	req_t req;
	rsp_t rsp;
	logic take;
	logic m_tvalid_q;
	logic [FRAME_W-1:0] first_q;
	logic [OC_W-1:0]    oc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_frame      <= '0;
			cfg_q.pool_frames     <= CFG_CNT_W'(1024);
			cfg_q.reserved_frames <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE: cfg_q.base_frame      <= cfg_data;
				CFG_POOL: cfg_q.pool_frames     <= cfg_data[CFG_CNT_W-1:0];
				CFG_RESV: cfg_q.reserved_frames <= cfg_data[CFG_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req.action       = s_tuser;
	assign req.frame_number = s_tdata[19:0];
	assign req.frame_count  = s_tdata[30:20];
	assign s_tready         = rsp.ready;
	assign take             = !m_tvalid_q || m_tready;

	cfa_engine #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (s_tvalid && rsp.ready),
		.req   (req),
		.cfg   (cfg_q),
		.take  (take),
		.rsp   (rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rsp.done && take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done && take) begin
			first_q <= rsp.first_frame;
			oc_q    <= rsp.outcome;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, oc_q, first_q};

endmodule
